// ----- design/mrg_pkg.sv -----
// Package for the interval merge block: default sizes and the tag that
// travels with every sorted interval from the sorter to the merger.
// No dependencies.
package mrg_pkg;

	localparam int MAX_INTERVALS_DEF = 64;
	localparam int COORD_WIDTH_DEF   = 16;
	localparam int LINK_DEPTH        = 2;

	// Per-interval control bits on the sorter-to-merger link
	typedef struct packed {
		logic last;   // final sorted interval of the set
		logic ovf;    // the set lost intervals at load time
	} tag_t;

endpackage

// ----- design/mrg_front.sv -----
// Front part of the interval merge block: insertion-sorting cells that load
// one interval per cycle and drain the sorted set in ascending start order.
// Depends on mrg_pkg.
module mrg_front #(
	parameter int MAX_INTERVALS = mrg_pkg::MAX_INTERVALS_DEF,
	parameter int COORD_WIDTH   = mrg_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] interval_start,
	input  logic signed [COORD_WIDTH-1:0] interval_end,
	input  logic                          last_interval,
	output logic                          link_push,
	input  logic                          link_full,
	output logic signed [COORD_WIDTH-1:0] link_start,
	output logic signed [COORD_WIDTH-1:0] link_end,
	output mrg_pkg::tag_t                 link_tag
);

	localparam int NW = $clog2(MAX_INTERVALS + 1);
	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                          state_q;
	logic [NW-1:0]                 cnt_q;
	logic                          dropped_q;
	logic                          ovf_q;
	logic signed [COORD_WIDTH-1:0] cell_s_q [MAX_INTERVALS];
	logic signed [COORD_WIDTH-1:0] cell_e_q [MAX_INTERVALS];
	logic [MAX_INTERVALS-1:0]      gt;
	logic                          accept;
	logic                          room;
	logic                          drain_step;

	assign full       = (state_q == ST_DRAIN);
	assign accept     = push && !full;
	assign room       = (cnt_q < NW'(MAX_INTERVALS));
	assign drain_step = (state_q == ST_DRAIN) && !link_full;

	// Flag held cells whose start is strictly above the new start
	always_comb begin
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			gt[i] = (NW'(i) < cnt_q) && (cell_s_q[i] > interval_start);
		end
	end

	// Insert behind equal starts, or shift the set down one cell on drain
	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (accept && room) begin
				if ((i > 0) && gt[(i > 0) ? i - 1 : 0]) begin
					cell_s_q[i] <= cell_s_q[(i > 0) ? i - 1 : 0];
					cell_e_q[i] <= cell_e_q[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || (NW'(i) == cnt_q)) begin
					cell_s_q[i] <= interval_start;
					cell_e_q[i] <= interval_end;
				end
			end else if (drain_step && (i < MAX_INTERVALS - 1)) begin
				cell_s_q[i] <= cell_s_q[(i < MAX_INTERVALS - 1) ? i + 1 : i];
				cell_e_q[i] <= cell_e_q[(i < MAX_INTERVALS - 1) ? i + 1 : i];
			end
		end
	end

	// Count loads, note drops, close the set and count down the drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (room) begin
							cnt_q <= cnt_q + NW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_interval) begin
							state_q <= ST_DRAIN;
							ovf_q   <= dropped_q || !room;
						end
					end
				end
				ST_DRAIN: begin
					if (drain_step) begin
						cnt_q <= cnt_q - NW'(1);
						if (cnt_q == NW'(1)) begin
							state_q   <= ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Head cell goes out on the link
	assign link_push     = drain_step;
	assign link_start    = cell_s_q[0];
	assign link_end      = cell_e_q[0];
	assign link_tag.last = (cnt_q == NW'(1));
	assign link_tag.ovf  = ovf_q;

endmodule

// ----- design/mrg_link.sv -----
// Short queue between the sorter and the merger of the interval merge block.
// Generic width and depth; no package dependency.
module mrg_link #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [WIDTH-1:0]           data_in,
	input  logic                       pop,
	output logic                       empty,
	output logic [WIDTH-1:0]           data_out,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (level_q == LW'(DEPTH));
	assign empty    = (level_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];
	assign level    = level_q;

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LW'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

// ----- design/mrg_back.sv -----
// Back part of the interval merge block: folds sorted intervals into merged
// runs and holds each finished run in an output register.
// Depends on mrg_pkg.
module mrg_back #(
	parameter int COORD_WIDTH = mrg_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          link_empty,
	output logic                          link_pop,
	input  logic signed [COORD_WIDTH-1:0] link_start,
	input  logic signed [COORD_WIDTH-1:0] link_end,
	input  mrg_pkg::tag_t                 link_tag,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_WIDTH-1:0] merged_start,
	output logic signed [COORD_WIDTH-1:0] merged_end,
	output logic                          last_merged,
	output logic                          overflow
);

	logic signed [COORD_WIDTH-1:0] cur_s_q;
	logic signed [COORD_WIDTH-1:0] cur_e_q;
	logic                          have_q;
	logic                          flush_q;
	logic                          ovf_q;
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] out_s_q;
	logic signed [COORD_WIDTH-1:0] out_e_q;
	logic                          out_last_q;
	logic                          out_ovf_q;
	logic                          out_ready;
	logic                          joins;
	logic                          emit_prev;

	assign out_ready = !out_valid_q || pop;
	assign link_pop  = out_ready && !flush_q && !link_empty;
	assign joins     = have_q && (link_start <= cur_e_q);
	assign emit_prev = link_pop && have_q && !joins;

	// Merge or open a run; after a set's last interval, flush the open run once the output register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && flush_q) begin
				out_valid_q <= 1'b1;
				flush_q     <= 1'b0;
				have_q      <= 1'b0;
			end else begin
				if (link_pop) begin
					have_q <= 1'b1;
					if (link_tag.last) begin
						flush_q <= 1'b1;
					end
				end
				if (emit_prev) begin
					out_valid_q <= 1'b1;
				end else if (pop) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// Run and output payload
	always_ff @(posedge clk) begin
		if (out_ready && flush_q) begin
			out_s_q    <= cur_s_q;
			out_e_q    <= cur_e_q;
			out_last_q <= 1'b1;
			out_ovf_q  <= ovf_q;
		end else if (link_pop) begin
			ovf_q <= link_tag.ovf;
			if (joins) begin
				if (link_end > cur_e_q) begin
					cur_e_q <= link_end;
				end
			end else begin
				cur_s_q <= link_start;
				cur_e_q <= link_end;
			end
			if (emit_prev) begin
				out_s_q    <= cur_s_q;
				out_e_q    <= cur_e_q;
				out_last_q <= 1'b0;
				out_ovf_q  <= ovf_q;
			end
		end
	end

	assign empty        = !out_valid_q;
	assign merged_start = out_s_q;
	assign merged_end   = out_e_q;
	assign last_merged  = out_last_q;
	assign overflow     = out_ovf_q;

endmodule

// ----- design/merge_overlapping_intervals_top.sv -----
// Interval merge: insertion-sorting cells load one interval per cycle while
// input is accepted; the closing transfer starts a drain of the sorted set
// over the link, with input held off (full) until the sorter is empty. Merged
// results leave through an output register, at most one per cycle.
// Reset clears counts, control flags and queue levels; stored intervals and result payload are not reset.
module merge_overlapping_intervals_top #(
	parameter int MAX_INTERVALS = mrg_pkg::MAX_INTERVALS_DEF,
	parameter int COORD_WIDTH   = mrg_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] interval_start,
	input  logic signed [COORD_WIDTH-1:0] interval_end,
	input  logic                          last_interval,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [COORD_WIDTH-1:0] merged_start,
	output logic signed [COORD_WIDTH-1:0] merged_end,
	output logic                          last_merged,
	output logic                          overflow
);

	localparam int TW = $bits(mrg_pkg::tag_t);
	localparam int LINK_W = 2 * COORD_WIDTH + TW;
	localparam int LVL_W = $clog2(mrg_pkg::LINK_DEPTH + 1);

	logic                          link_push;
	logic                          link_full;
	logic signed [COORD_WIDTH-1:0] f_start;
	logic signed [COORD_WIDTH-1:0] f_end;
	mrg_pkg::tag_t                 f_tag;
	logic [LINK_W-1:0]             link_in;
	logic [LINK_W-1:0]             link_out;
	logic                          link_pop;
	logic                          link_empty;
	logic [LVL_W-1:0]              link_level;
	mrg_pkg::tag_t                 b_tag;

	// Sorting front
	mrg_front #(
		.MAX_INTERVALS(MAX_INTERVALS),
		.COORD_WIDTH  (COORD_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.interval_start(interval_start),
		.interval_end  (interval_end),
		.last_interval (last_interval),
		.link_push     (link_push),
		.link_full     (link_full),
		.link_start    (f_start),
		.link_end      (f_end),
		.link_tag      (f_tag)
	);

	// Pack and queue sorted intervals
	assign link_in = {f_tag, f_start, f_end};

	mrg_link #(
		.WIDTH(LINK_W),
		.DEPTH(mrg_pkg::LINK_DEPTH)
	) u_link (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (link_push),
		.full    (link_full),
		.data_in (link_in),
		.pop     (link_pop),
		.empty   (link_empty),
		.data_out(link_out),
		.level   (link_level)
	);

	assign b_tag = mrg_pkg::tag_t'(link_out[LINK_W-1 -: TW]);

	// Merging back
	mrg_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.link_empty  (link_empty),
		.link_pop    (link_pop),
		.link_start  (link_out[2*COORD_WIDTH-1 -: COORD_WIDTH]),
		.link_end    (link_out[COORD_WIDTH-1:0]),
		.link_tag    (b_tag),
		.empty       (empty),
		.pop         (pop),
		.merged_start(merged_start),
		.merged_end  (merged_end),
		.last_merged (last_merged),
		.overflow    (overflow)
	);

	// Closing a set stops input until the sorter drains
	a_close_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && last_interval) |=> full)
		else $error("input not held off after the closing interval");

	// The link never holds more than its depth
	a_link_level: assert property (@(posedge clk) disable iff (!arst_n)
		link_level <= LVL_W'(mrg_pkg::LINK_DEPTH))
		else $error("link queue level beyond depth");

	// The sorter only sends while it is draining
	a_push_drain: assert property (@(posedge clk) disable iff (!arst_n)
		link_push |-> full)
		else $error("sorter sent an interval outside its drain");

endmodule

// ----- tb/merge_overlapping_intervals_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for merge_overlapping_intervals_top: sends interval
// sets, predicts the sorted and merged output and checks every transfer.
// Depends on mrg_pkg and the merge_overlapping_intervals_top RTL.
module merge_overlapping_intervals_top_tb;

	localparam int CW        = mrg_pkg::COORD_WIDTH_DEF;
	localparam int MAX_SET   = mrg_pkg::MAX_INTERVALS_DEF;
	localparam int LIMIT     = 400000;
	localparam int PRINT_CAP = 40;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t start_pt;
		coord_t end_pt;
		logic   is_last;
		logic   dropped;
	} merged_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   push = 1'b0;
	logic   pop = 1'b0;
	coord_t interval_start = '0;
	coord_t interval_end = '0;
	logic   last_interval = 1'b0;
	logic   full;
	logic   empty;
	coord_t merged_start;
	coord_t merged_end;
	logic   last_merged;
	logic   overflow;

	// Predictor state: the set gathered so far
	coord_t  set_starts [MAX_SET];
	coord_t  set_ends [MAX_SET];
	int      set_count = 0;
	bit      set_dropped = 1'b0;
	merged_t expected_merged [$];

	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;

	merge_overlapping_intervals_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.interval_start (interval_start),
		.interval_end   (interval_end),
		.last_interval  (last_interval),
		.empty          (empty),
		.pop            (pop),
		.merged_start   (merged_start),
		.merged_end     (merged_end),
		.last_merged    (last_merged),
		.overflow       (overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Store one accepted interval; on the closing item sort, merge and queue
	function automatic void load_interval(coord_t s, coord_t e, logic last);
		coord_t  ss [MAX_SET];
		coord_t  ee [MAX_SET];
		coord_t  ks, ke, cur_s, cur_e;
		int      i, j;
		merged_t r;
		if (set_count < MAX_SET) begin
			set_starts[set_count] = s;
			set_ends[set_count] = e;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!last)
			return;
		// stable insertion sort by start
		for (i = 0; i < set_count; i++) begin
			ks = set_starts[i];
			ke = set_ends[i];
			j = i;
			while (j > 0 && ss[j-1] > ks) begin
				ss[j] = ss[j-1];
				ee[j] = ee[j-1];
				j--;
			end
			ss[j] = ks;
			ee[j] = ke;
		end
		// fold each interval that starts within the running end
		cur_s = ss[0];
		cur_e = ee[0];
		for (i = 1; i <= set_count; i++) begin
			if (i < set_count && ss[i] <= cur_e) begin
				if (ee[i] > cur_e)
					cur_e = ee[i];
			end else begin
				r.start_pt = cur_s;
				r.end_pt = cur_e;
				r.is_last = (i == set_count);
				r.dropped = set_dropped;
				expected_merged.insert(expected_merged.size(), r);
				if (i < set_count) begin
					cur_s = ss[i];
					cur_e = ee[i];
				end
			end
		end
		set_count = 0;
		set_dropped = 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Compare one result transfer with the oldest expected interval
	task automatic check_merged();
		merged_t want;
		if (expected_merged.size() == 0) begin
			report_mismatch($sformatf("unexpected result [%0d, %0d]", merged_start,
				merged_end));
			return;
		end
		want = expected_merged.pop_front();
		if (merged_start !== want.start_pt)
			report_mismatch($sformatf("merged_start %0d, want %0d", merged_start,
				want.start_pt));
		if (merged_end !== want.end_pt)
			report_mismatch($sformatf("merged_end %0d, want %0d", merged_end, want.end_pt));
		if (last_merged !== want.is_last)
			report_mismatch($sformatf("last_merged %0b, want %0b", last_merged, want.is_last));
		if (overflow !== want.dropped)
			report_mismatch($sformatf("overflow %0b, want %0b", overflow, want.dropped));
	endtask

	// Receive side: check on each transfer, stall pop at random
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_merged();
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Drive one interval and hold it until the transfer; push stays high on return
	task automatic send_interval(input int s, input int e, input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		interval_start <= coord_t'(s);
		interval_end <= coord_t'(e);
		last_interval <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		load_interval(coord_t'(s), coord_t'(e), last);
	endtask

	// Hold off input until every expected interval has come out
	task automatic wait_drain(input int extra);
		push <= 1'b0;
		while (expected_merged.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	function automatic int clamp_coord(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	// Single intervals, the widest one and one with its end below its start
	task automatic test_single_intervals();
		send_interval(-32768, 32767, 1'b1);
		send_interval(32767, -32768, 1'b1);
		send_interval(0, 0, 1'b1);
		wait_drain(4);
	endtask

	// Touching intervals merge, a gap of one keeps them apart
	task automatic test_touch_and_gap();
		send_interval(4, 5, 1'b0);
		send_interval(13, 14, 1'b0);
		send_interval(1, 3, 1'b0);
		send_interval(10, 12, 1'b0);
		send_interval(3, 4, 1'b1);
		wait_drain(4);
	endtask

	// Nesting, equal starts in both arrival orders, low end inside a group
	task automatic test_nested_and_equal_starts();
		send_interval(0, 100, 1'b0);
		send_interval(10, 20, 1'b0);
		send_interval(50, 60, 1'b0);
		send_interval(-5, 0, 1'b1);
		send_interval(5, 2, 1'b0);
		send_interval(5, 9, 1'b1);
		send_interval(5, 9, 1'b0);
		send_interval(5, 2, 1'b1);
		send_interval(0, 10, 1'b0);
		send_interval(2, -100, 1'b0);
		send_interval(20, 30, 1'b1);
		wait_drain(4);
	endtask

	task automatic test_extreme_points();
		send_interval(32767, 32767, 1'b0);
		send_interval(-32768, -32768, 1'b0);
		send_interval(-32768, -32767, 1'b0);
		send_interval(32766, 32767, 1'b1);
		wait_drain(4);
	endtask

	// Fill the store with disjoint intervals in shuffled order, then overrun it
	// with a closing item that is itself dropped
	task automatic test_store_limit();
		int order [MAX_SET];
		int i, j, tmp;
		for (i = 0; i < MAX_SET; i++)
			order[i] = i;
		for (i = MAX_SET - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (i = 0; i < MAX_SET; i++)
			send_interval(order[i] * 100 - 3200, order[i] * 100 - 3190, 1'b0);
		send_interval(rand_coord(), rand_coord(), 1'b1);
		wait_drain(4);
	endtask

	// Random sets: mostly small and crowded so that they overlap
	task automatic test_random_sets(input int n_items, input int s_pct, input int r_pct);
		int  sent, size, base, span, s, e, k;
		bit  narrow;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		sent = 0;
		while (sent < n_items) begin
			size = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			if (size > n_items - sent)
				size = n_items - sent;
			narrow = ($urandom_range(3) != 0);
			base = rand_coord();
			span = $urandom_range(1, 60);
			for (k = 0; k < size; k++) begin
				if (narrow) begin
					s = clamp_coord(base + int'($urandom_range(8 * span)));
					e = clamp_coord(s + int'($urandom_range(span)));
				end else begin
					s = rand_coord();
					e = $urandom_range(1) ? rand_coord()
						: clamp_coord(s + int'($urandom_range(4000)));
				end
				if ($urandom_range(9) == 0)
					e = clamp_coord(s - int'($urandom_range(1, span)));
				send_interval(s, e, k == size - 1);
			end
			sent += size;
			if ($urandom_range(5) == 0)
				wait_drain(1);
		end
		wait_drain(4);
	endtask

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("merge_overlapping_intervals_top regression: fail");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 11;
		recv_idle_pct = 52;
		test_single_intervals();
		test_touch_and_gap();
		test_nested_and_equal_starts();
		test_extreme_points();
		test_store_limit();
		test_random_sets(7, 11, 52);
		test_random_sets(7, 52, 11);
		test_random_sets(7, 0, 0);
		wait_drain(20);
		if (mismatch_count == 0 && expected_merged.size() == 0) begin
			$display("merge_overlapping_intervals_top regression: pass");
		end else begin
			$display("merge_overlapping_intervals_top regression: fail");
		end
		$finish;
	end

endmodule
